/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, checked only out of reset.
`define SQSH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every edge out of reset.
`define SQSH_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

/* rtl/sqsh_pkg.sv */
`default_nettype none
package sqsh_pkg;

  localparam int unsigned HDR_BYTES = 19;
  localparam int unsigned HDR_CNT_W = 5;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALTED  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_MAGIC = 3'd1,
    ST_TRUNC_HDR = 3'd2,
    ST_OVERRUN   = 3'd3,
    ST_BAD_METH  = 3'd4
  } status_t;

  localparam logic [7:0] METH_STORED  = 8'd0;
  localparam logic [7:0] METH_DEFLATE = 8'd2;

  // Header offsets
  localparam logic [HDR_CNT_W-1:0] OFS_METHOD  = HDR_CNT_W'(5);
  localparam logic [HDR_CNT_W-1:0] OFS_ENCRYPT = HDR_CNT_W'(6);
  localparam logic [HDR_CNT_W-1:0] OFS_PLEN    = HDR_CNT_W'(7);
  localparam logic [HDR_CNT_W-1:0] OFS_XLEN    = HDR_CNT_W'(11);
  localparam logic [HDR_CNT_W-1:0] OFS_LAST    = HDR_CNT_W'(HDR_BYTES - 1);

  // "SQSH"
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h53;
      2'd1:    m = 8'h51;
      2'd2:    m = 8'h53;
      default: m = 8'h48;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

/* rtl/sqsh_chunk_deframer_decrypt_core.sv */
// Channel | Ports           | Contents (lowest bit first)
// in      | in_t*           | tdata: data_byte; tuser: start_chunk; tlast: end_of_archive
// out     | out_t*          | tdata: out_byte, expanded_size, status; tuser: byte_valid,
//         |                 | deflated; tlast: chunk_end
// One input item per cycle while in_tready is high; its result is output the next cycle.
// All parsing and decryption is one pass of logic between the state/input side and the
// result register; the 32-bit payload index compare sets the path.
// An item is taken whenever the result register is empty or being drained.
// rst_n is synchronous, active low; after reset the parser waits for header byte zero.
`default_nettype none
`include "assert_macros.svh"
module sqsh_chunk_deframer_decrypt_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] start_chunk
  input  wire logic        in_tlast,   // end_of_archive
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [7:0] out_byte, [39:8] expanded_size, [42:40] status
  output logic [1:0]       out_tuser,  // [0] byte_valid, [1] deflated
  output logic             out_tlast   // chunk_end
);
  import sqsh_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [HDR_CNT_W-1:0]   hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]             meth_r, meth_nxt;
  logic                   enc_r, enc_nxt;
  logic [31:0]            plen_r, plen_nxt;
  logic [31:0]            xlen_r, xlen_nxt;
  logic [31:0]            idx_r, idx_nxt;

  logic                   out_vld_r;
  logic [7:0]             o_byte_r;
  logic                   o_bvalid_r, o_defl_r, o_end_r;
  logic [31:0]            o_size_r;
  status_t                o_st_r;

  logic                   in_acc;
  logic                   res_vld;
  logic [7:0]             res_byte;
  logic                   res_bvalid, res_defl, res_end;
  logic [31:0]            res_size;
  status_t                res_st;

  logic [7:0]             b;
  logic [HDR_CNT_W-1:0]   n;
  logic [HDR_CNT_W-1:0]   pofs, xofs;
  logic [7:0]             k;
  logic                   final_byte;

  assign in_tready = !out_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign b         = in_tdata;

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    meth_nxt    = meth_r;
    enc_nxt     = enc_r;
    plen_nxt    = plen_r;
    xlen_nxt    = xlen_r;
    idx_nxt     = idx_r;
    res_vld     = 1'b0;
    res_byte    = 8'd0;
    res_bvalid  = 1'b0;
    res_defl    = 1'b0;
    res_end     = 1'b1;
    res_size    = 32'd0;
    res_st      = ST_OK;
    n           = in_tuser ? '0 : hdr_cnt_r;
    pofs        = n - OFS_PLEN;
    xofs        = n - OFS_XLEN;
    k           = idx_r[7:0];
    final_byte  = (idx_r + 32'd1) == plen_r;

    if (in_tuser) begin
      phase_nxt   = PH_HEADER;
      hdr_cnt_nxt = '0;
    end

    case (in_tuser ? PH_HEADER : phase_r)
      PH_HEADER: begin
        if (n < HDR_CNT_W'(4) && b != magic_byte(n[1:0])) begin
          res_vld     = 1'b1;
          res_st      = ST_BAD_MAGIC;
          phase_nxt   = PH_HALTED;
          hdr_cnt_nxt = '0;
        end else begin
          if (n == OFS_METHOD) begin
            meth_nxt = b;
          end else if (n == OFS_ENCRYPT) begin
            enc_nxt = (b != 8'd0);
          end else if (n >= OFS_PLEN && n < OFS_XLEN) begin
            plen_nxt[8*pofs[1:0] +: 8] = b;
          end else if (n >= OFS_XLEN && n < OFS_XLEN + HDR_CNT_W'(4)) begin
            xlen_nxt[8*xofs[1:0] +: 8] = b;
          end
          if (n < OFS_LAST) begin
            if (in_tlast) begin
              res_vld     = 1'b1;
              res_st      = ST_TRUNC_HDR;
              phase_nxt   = PH_HALTED;
              hdr_cnt_nxt = '0;
            end else begin
              hdr_cnt_nxt = n + HDR_CNT_W'(1);
            end
          end else if (in_tlast && plen_r != 32'd0) begin
            res_vld     = 1'b1;
            res_st      = ST_OVERRUN;
            phase_nxt   = PH_HALTED;
            hdr_cnt_nxt = '0;
          end else if (meth_nxt != METH_STORED && meth_nxt != METH_DEFLATE) begin
            res_vld     = 1'b1;
            res_st      = ST_BAD_METH;
            phase_nxt   = PH_HALTED;
            hdr_cnt_nxt = '0;
          end else begin
            hdr_cnt_nxt = '0;
            idx_nxt     = 32'd0;
            if (plen_r == 32'd0) begin
              // empty chunk: one marker result, stay in header
              phase_nxt = PH_HEADER;
              res_vld   = 1'b1;
              res_defl  = (meth_nxt == METH_DEFLATE);
              res_size  = xlen_r;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        res_vld = 1'b1;
        if (!final_byte && in_tlast) begin
          res_st      = ST_OVERRUN;
          phase_nxt   = PH_HALTED;
          hdr_cnt_nxt = '0;
        end else begin
          res_byte   = enc_r ? ((b - k) ^ k) : b;
          res_bvalid = 1'b1;
          res_defl   = (meth_r == METH_DEFLATE);
          res_end    = final_byte;
          res_size   = xlen_r;
          if (final_byte) begin
            phase_nxt   = PH_HEADER;
            hdr_cnt_nxt = '0;
            idx_nxt     = 32'd0;
          end else begin
            idx_nxt = idx_r + 32'd1;
          end
        end
      end
      default: begin
        // halted: drop bytes until a restart
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= '0;
      meth_r    <= 8'd0;
      enc_r     <= 1'b0;
      plen_r    <= 32'd0;
      xlen_r    <= 32'd0;
      idx_r     <= 32'd0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      meth_r    <= meth_nxt;
      enc_r     <= enc_nxt;
      plen_r    <= plen_nxt;
      xlen_r    <= xlen_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_acc && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_vld) begin
      o_byte_r   <= res_byte;
      o_bvalid_r <= res_bvalid;
      o_defl_r   <= res_defl;
      o_end_r    <= res_end;
      o_size_r   <= res_size;
      o_st_r     <= res_st;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, o_st_r, o_size_r, o_byte_r};
  assign out_tuser  = {o_defl_r, o_bvalid_r};
  assign out_tlast  = o_end_r;

  `SQSH_ASSERT_IMP(a_err_shape, out_tvalid && o_st_r != ST_OK,
    o_end_r && !o_bvalid_r && !o_defl_r && o_size_r == 32'd0,
    "error item must carry only chunk_end and status")
  `SQSH_ASSERT_IMP(a_err_halts, in_acc && res_vld && res_st != ST_OK,
    ##1 phase_r == PH_HALTED, "error did not halt the parser")
  `SQSH_ASSERT(a_cnt_idle, phase_r == PH_HEADER || hdr_cnt_r == '0,
    "header count left nonzero outside header phase")
  `SQSH_ASSERT(a_cnt_range, hdr_cnt_r <= OFS_LAST,
    "header count past last header byte")

endmodule
`default_nettype wire
